[rtl/pstk_pkg.sv]
// ----------------------------------------------------------------------------
// pstk_pkg
// shared constants, types and helpers of the pair sum top-k spread unit
// ----------------------------------------------------------------------------
`default_nettype none

package pstk_pkg;

    localparam int MAX_BAGS    = 64;
    localparam int WEIGHT_BITS = 30;
    localparam int BAGS_BITS   = 7;
    localparam int TOTAL_BITS  = 37;
    localparam int NCELL       = MAX_BAGS - 1;
    localparam int SUM_BITS    = WEIGHT_BITS + 1;
    localparam int FILL_BITS   = $clog2(MAX_BAGS);
    localparam int SEEN_BITS   = $clog2(MAX_BAGS + 1);

    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [TOTAL_BITS-1:0]  total_t;
    typedef logic [FILL_BITS-1:0]   fill_t;
    typedef logic [SEEN_BITS-1:0]   seen_t;
    typedef logic [BAGS_BITS-1:0]   bags_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic trim;
        logic step;
        logic emit;
    } pstk_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_trim;
        logic last;
        logic out_free;
    } pstk_status_t;

    // strict ordering used by both lists
    function automatic logic better(sum_t a, sum_t b, logic upper);
        return upper ? (a > b) : (a < b);
    endfunction

    // effective group count, clamped to 1 .. MAX_BAGS
    function automatic seen_t clamp_bags(bags_t b);
        if (b == '0)
            return seen_t'(1);
        else if (int'(b) > MAX_BAGS)
            return seen_t'(MAX_BAGS);
        else
            return seen_t'(b);
    endfunction

endpackage

`default_nettype wire

[rtl/pstk_if.sv]
// ----------------------------------------------------------------------------
// pstk_if
// valid/ready channels of the pair sum top-k spread unit
// ----------------------------------------------------------------------------
`default_nettype none

interface pstk_in_if;
    logic               valid;
    logic               ready;
    pstk_pkg::weight_t  weight;
    logic               last;

    modport source (output valid, output weight, output last, input ready);
    modport sink   (input valid, input weight, input last, output ready);
endinterface

interface pstk_out_if;
    logic              valid;
    logic              ready;
    pstk_pkg::total_t  spread;
    logic              too_few;

    modport source (output valid, output spread, output too_few, input ready);
    modport sink   (input valid, input spread, input too_few, output ready);
endinterface

interface pstk_cfg_if;
    logic             valid;
    logic             ready;
    pstk_pkg::bags_t  bags;

    modport source (output valid, output bags, input ready);
    modport sink   (input valid, input bags, output ready);
endinterface

`default_nettype wire

[rtl/pair_sum_topk_spread_unit.sv]
// ----------------------------------------------------------------------------
// pair_sum_topk_spread_unit
// streaming top-k / bottom-k pair sum selection with spread result
// ----------------------------------------------------------------------------
// sequence: accept, insert, and an emit for a last-marked weight; one trim step
//   per entry trimmed after a lowered group count; no new weight is taken
//   until the previous one is done; the result is registered at emit, later
//   by any trim steps and while the previous result is unread
// reset: group count is 1, stream state cleared at once, no clearing pass
`default_nettype none

module pair_sum_topk_spread_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pstk_cfg_if.sink      cfg,
    pstk_in_if.sink       in_item,
    pstk_out_if.source    out_item
);

    // command and status between sequencer and datapath
    pstk_pkg::pstk_cmd_t     cmd;
    pstk_pkg::pstk_status_t  status;
    logic                    in_ready;

    // sequencer: one transfer per visit to idle, then trim / insert / emit
    pstk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign in_item.ready = in_ready;

    // datapath: two compare-and-shift chains (largest and smallest pair sums),
    // shared fill count, running totals and the output register, which lets
    // the next stream start while a result still waits
    pstk_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg      (cfg),
        .in_item  (in_item),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

[rtl/pstk_list.sv]
// ----------------------------------------------------------------------------
// pstk_list
// chain of compare-and-shift slots holding one sorted selection and its total
// ----------------------------------------------------------------------------
`default_nettype none

module pstk_list (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              is_large,
    input  wire pstk_pkg::sum_t    x,
    input  wire pstk_pkg::fill_t   fill,
    input  wire logic              full,
    input  wire logic              do_insert,
    input  wire logic              do_trim,
    input  wire logic              do_clear,
    output pstk_pkg::total_t       total
);

    // entries are right aligned: worst entry sits in the last slot
    pstk_pkg::sum_t                  slot_reg  [pstk_pkg::NCELL];
    pstk_pkg::sum_t                  slot_next [pstk_pkg::NCELL];
    logic [pstk_pkg::NCELL-1:0]      valid;
    logic [pstk_pkg::NCELL-1:0]      ahead;
    logic [pstk_pkg::NCELL-1:0]      behind;
    logic [pstk_pkg::NCELL-1:0]      gap;
    logic                            evict;
    pstk_pkg::total_t                total_reg;
    pstk_pkg::total_t                total_next;
    pstk_pkg::total_t                worst_ext;
    pstk_pkg::total_t                x_ext;

    always_comb
    begin
        for (int i = 0; i < pstk_pkg::NCELL; i++)
        begin
            valid[i]  = (int'(fill) + i >= pstk_pkg::NCELL);
            gap[i]    = (int'(fill) + i == pstk_pkg::NCELL - 1);
            ahead[i]  = valid[i] & ~pstk_pkg::better(x, slot_reg[i], is_large);
            behind[i] = valid[i] &  pstk_pkg::better(x, slot_reg[i], is_large);
        end
    end

    assign evict = behind[pstk_pkg::NCELL-1];

    genvar g;
    generate
        for (g = 0; g < pstk_pkg::NCELL; g++)
        begin : g_slot
            pstk_pkg::sum_t from_right;
            pstk_pkg::sum_t from_left;
            logic           right_ahead;
            logic           left_behind;

            if (g < pstk_pkg::NCELL - 1)
            begin : g_right
                assign from_right  = slot_reg[g+1];
                assign right_ahead = ahead[g+1];
            end
            else
            begin : g_right_end
                assign from_right  = x;
                assign right_ahead = 1'b0;
            end

            if (g > 0)
            begin : g_left
                assign from_left   = slot_reg[g-1];
                assign left_behind = behind[g-1];
            end
            else
            begin : g_left_end
                assign from_left   = slot_reg[0];
                assign left_behind = 1'b0;
            end

            always_comb
            begin
                slot_next[g] = slot_reg[g];
                if (do_trim)
                begin
                    slot_next[g] = from_left;
                end
                else if (do_insert && !full)
                begin
                    // entries at least as good as x move one slot left
                    if (right_ahead)
                        slot_next[g] = from_right;
                    else if (ahead[g] || gap[g])
                        slot_next[g] = x;
                end
                else if (do_insert && evict)
                begin
                    // entries worse than x move one slot right, worst drops out
                    if (behind[g])
                        slot_next[g] = left_behind ? from_left : x;
                end
            end

            always_ff @(posedge clk)
            begin
                slot_reg[g] <= slot_next[g];
            end
        end
    endgenerate

    assign worst_ext = pstk_pkg::total_t'(slot_reg[pstk_pkg::NCELL-1]);
    assign x_ext     = pstk_pkg::total_t'(x);

    always_comb
    begin
        total_next = total_reg;
        if (do_clear)
            total_next = '0;
        else if (do_trim)
            total_next = total_reg - worst_ext;
        else if (do_insert && !full)
            total_next = total_reg + x_ext;
        else if (do_insert && evict)
            total_next = total_reg - worst_ext + x_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else
            total_reg <= total_next;
    end

    assign total = total_reg;

endmodule

`default_nettype wire

[rtl/pstk_dp.sv]
// ----------------------------------------------------------------------------
// pstk_dp
// datapath: input latch, pair sum, both selections, counters, result register
// ----------------------------------------------------------------------------
`default_nettype none

module pstk_dp (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pstk_pkg::pstk_cmd_t     cmd,
    output pstk_pkg::pstk_status_t       status,
    pstk_cfg_if.sink                     cfg,
    pstk_in_if.sink                      in_item,
    pstk_out_if.source                   out_item
);

    pstk_pkg::bags_t    bags_reg;
    pstk_pkg::weight_t  weight_reg;
    pstk_pkg::sum_t     pair_reg;
    logic               last_reg;
    pstk_pkg::weight_t  prev_reg;
    pstk_pkg::seen_t    seen_reg;
    pstk_pkg::seen_t    seen_next;
    pstk_pkg::fill_t    fill_reg;
    pstk_pkg::fill_t    fill_next;
    pstk_pkg::total_t   spread_reg;
    logic               too_few_reg;
    logic               out_valid_reg;

    pstk_pkg::seen_t    k_eff;
    pstk_pkg::fill_t    keep;
    logic               full;
    logic               do_insert;
    pstk_pkg::total_t   large_total;
    pstk_pkg::total_t   small_total;
    logic               too_few;
    pstk_pkg::total_t   spread;

    assign k_eff     = pstk_pkg::clamp_bags(bags_reg);
    assign keep      = pstk_pkg::fill_t'(k_eff - pstk_pkg::seen_t'(1));
    assign full      = (fill_reg == keep);
    assign do_insert = cmd.step && (seen_reg != '0);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bags_reg <= pstk_pkg::bags_t'(1);
        else if (cfg.valid)
            bags_reg <= cfg.bags;
    end

    // input latch with the pair sum formed against the previous weight
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            weight_reg <= in_item.weight;
            last_reg   <= in_item.last;
            pair_reg   <= pstk_pkg::sum_t'(prev_reg) + pstk_pkg::sum_t'(in_item.weight);
        end
    end

    pstk_list u_large (
        .clk       (clk),
        .rst_n     (rst_n),
        .is_large  (1'b1),
        .x         (pair_reg),
        .fill      (fill_reg),
        .full      (full),
        .do_insert (do_insert),
        .do_trim   (cmd.trim),
        .do_clear  (cmd.emit),
        .total     (large_total)
    );

    pstk_list u_small (
        .clk       (clk),
        .rst_n     (rst_n),
        .is_large  (1'b0),
        .x         (pair_reg),
        .fill      (fill_reg),
        .full      (full),
        .do_insert (do_insert),
        .do_trim   (cmd.trim),
        .do_clear  (cmd.emit),
        .total     (small_total)
    );

    always_comb
    begin
        seen_next = seen_reg;
        fill_next = fill_reg;
        if (cmd.emit)
        begin
            seen_next = '0;
            fill_next = '0;
        end
        else if (cmd.trim)
        begin
            fill_next = fill_reg - pstk_pkg::fill_t'(1);
        end
        else if (cmd.step)
        begin
            if (int'(seen_reg) < pstk_pkg::MAX_BAGS)
                seen_next = seen_reg + pstk_pkg::seen_t'(1);
            if (do_insert && (fill_reg < keep))
                fill_next = fill_reg + pstk_pkg::fill_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            fill_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            fill_reg <= fill_next;
            if (cmd.emit)
                prev_reg <= '0;
            else if (cmd.step)
                prev_reg <= weight_reg;
        end
    end

    assign too_few = (seen_reg < k_eff);
    assign spread  = (too_few || (k_eff == pstk_pkg::seen_t'(1))) ? '0
                   : (large_total - small_total);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            spread_reg  <= spread;
            too_few_reg <= too_few;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_item.ready)
            out_valid_reg <= 1'b0;
    end

    assign out_item.valid   = out_valid_reg;
    assign out_item.spread  = spread_reg;
    assign out_item.too_few = too_few_reg;

    assign status.need_trim = (fill_reg > keep);
    assign status.last      = last_reg;
    assign status.out_free  = !out_valid_reg || out_item.ready;

endmodule

`default_nettype wire

[rtl/pstk_ctrl.sv]
// ----------------------------------------------------------------------------
// pstk_ctrl
// sequencer: accept, trim after a lowered group count, insert, emit
// ----------------------------------------------------------------------------
`default_nettype none

module pstk_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire pstk_pkg::pstk_status_t  status,
    output pstk_pkg::pstk_cmd_t          cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WORK = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = S_WORK;
            end
            S_WORK:
            begin
                if (status.need_trim)
                begin
                    cmd.trim = 1'b1;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = status.last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire
